// File: sv/scms_pkg.sv
// Shared types, constants and helpers for the spin chain midpoint step unit.
// No dependencies; the design modules and the testbench take names from here.
package scms_pkg;

  localparam int CompW = 32;
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] CFG_STEP_GAMMA = 2'd0;
  localparam logic [1:0] CFG_EXCHANGE   = 2'd1;
  localparam logic [1:0] CFG_BIAS_Z     = 2'd2;
  localparam logic [1:0] CFG_PUMP_X     = 2'd3;

  localparam logic [62:0] RST_STEP_GAMMA = 63'd18447;
  localparam logic [31:0] RST_EXCHANGE   = 32'd729808896;
  localparam logic [31:0] RST_BIAS_Z     = 32'd1677722;
  localparam logic [31:0] RST_PUMP_X     = 32'd50332;

  localparam logic [2:0] SUB_CRS0 = 3'd0;
  localparam logic [2:0] SUB_CRS1 = 3'd1;
  localparam logic [2:0] SUB_ABS  = 3'd2;
  localparam logic [2:0] SUB_PP0  = 3'd3;
  localparam logic [2:0] SUB_PP1  = 3'd4;
  localparam logic [2:0] SUB_PP2  = 3'd5;
  localparam logic [2:0] SUB_PP3  = 3'd6;
  localparam logic [2:0] SUB_K    = 3'd7;

  typedef logic [2:0][CompW-1:0] vec_t;

  typedef struct packed {
    vec_t m;
    vec_t l;
    vec_t r;
    logic chain_end;
  } job_t;

  typedef struct packed {
    logic vld;
    job_t job;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLD,
    ST_CRS,
    ST_MID,
    ST_RES
  } back_st_e;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

// File: sv/scms_in_if.sv
// Input channel carrying one spin per transaction.
// Depends on nothing.
interface scms_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mag_x;
  logic signed [31:0] mag_y;
  logic signed [31:0] mag_z;
  logic               last_spin;

  modport source(output valid, output mag_x, output mag_y, output mag_z, output last_spin,
                 input ready);
  modport sink(input valid, input mag_x, input mag_y, input mag_z, input last_spin,
               output ready);
endinterface

// File: sv/scms_out_if.sv
// Output channel carrying one updated spin per transaction.
// Depends on nothing.
interface scms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic               chain_end;

  modport source(output valid, output new_x, output new_y, output new_z, output chain_end,
                 input ready);
  modport sink(input valid, input new_x, input new_y, input new_z, input chain_end,
               output ready);
endinterface

// File: sv/scms_front.sv
// Front end: neighbour window and job builder, up to two jobs per spin.
// Depends on scms_pkg and scms_in_if.
module scms_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  scms_in_if.sink           spin_i,
  input  logic              q_full_i,
  output scms_pkg::q_item_t q_o
);

  scms_pkg::vec_t  lft_q, lft_d, cen_q, cen_d, cur;
  logic            cv_q, cv_d;
  scms_pkg::job_t  slot_q [2];
  scms_pkg::job_t  slot_d [2];
  logic [1:0]      sv_q, sv_d;
  scms_pkg::job_t  job_a, job_b;
  logic            acc, push;

  assign spin_i.ready = (sv_q == 2'b00);
  assign acc  = spin_i.valid && spin_i.ready;
  assign push = sv_q[0] && !q_full_i;

  assign q_o.vld = sv_q[0];
  assign q_o.job = slot_q[0];

  always_comb begin
    cur[0] = spin_i.mag_x;
    cur[1] = spin_i.mag_y;
    cur[2] = spin_i.mag_z;
    job_a.m = cen_q;
    job_a.l = lft_q;
    job_a.r = cur;
    job_a.chain_end = 1'b0;
    job_b.m = cur;
    job_b.l = cen_q;
    job_b.r = '0;
    job_b.chain_end = 1'b1;
  end

  always_comb begin
    lft_d = lft_q;
    cen_d = cen_q;
    cv_d  = cv_q;
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    sv_d = sv_q;
    if (push) begin
      slot_d[0] = slot_q[1];
      sv_d = {1'b0, sv_q[1]};
    end
    if (acc) begin
      if (spin_i.last_spin) begin
        lft_d = '0;
        cen_d = '0;
        cv_d  = 1'b0;
      end else begin
        lft_d = cen_q;
        cen_d = cur;
        cv_d  = 1'b1;
      end
      case ({cv_q, spin_i.last_spin})
        2'b11: begin
          slot_d[0] = job_a;
          slot_d[1] = job_b;
          sv_d = 2'b11;
        end
        2'b10: begin
          slot_d[0] = job_a;
          sv_d = 2'b01;
        end
        2'b01: begin
          slot_d[0] = job_b;
          sv_d = 2'b01;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lft_q <= '0;
      cen_q <= '0;
      cv_q  <= 1'b0;
      sv_q  <= 2'b00;
    end else begin
      lft_q <= lft_d;
      cen_q <= cen_d;
      cv_q  <= cv_d;
      sv_q  <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && spin_i.last_spin) |=> (!cv_q && lft_q == '0 && cen_q == '0))
    else $error("window not cleared after chain end");
  a_held_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cv_q) |=> sv_q[0])
    else $error("held spin produced no job");
  a_two_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cv_q && spin_i.last_spin) |=> (sv_q == 2'b11))
    else $error("chain end with held spin must queue two jobs");
`endif

endmodule

// File: sv/scms_queue.sv
// Job queue between front and back end.
// Depends on scms_pkg.
module scms_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scms_pkg::q_item_t push_i,
  output logic              full_o,
  output scms_pkg::q_item_t head_o,
  input  logic              pop_i
);

  scms_pkg::job_t                   mem_q [scms_pkg::QueueDepth];
  logic [scms_pkg::QPtrW-1:0]       wp_q, rp_q;
  logic [scms_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             push;

  assign full_o     = (cnt_q == scms_pkg::QCntW'(scms_pkg::QueueDepth));
  assign push       = push_i.vld && !full_o;
  assign head_o.vld = (cnt_q != '0);
  assign head_o.job = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_i.job;
    end
  end

endmodule

// File: sv/scms_back.sv
// Back end: midpoint update of one job on a shared 33x33 multiplier.
// Holds the configuration registers. Depends on scms_pkg and scms_out_if.
module scms_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [62:0]       cfg_data_i,
  input  scms_pkg::q_item_t q_i,
  output logic              q_pop_o,
  scms_out_if.source        result_o
);

  scms_pkg::back_st_e state_q, state_d;

  logic [62:0] gamma_q;
  logic [31:0] exch_q, biasz_q, pumpx_q;

  logic [2:0]   fld_q, fld_d;
  logic [1:0]   axis_q, axis_d;
  logic [2:0]   sub_q, sub_d;
  logic         stage_q, stage_d;
  logic         ph_q, ph_d;

  scms_pkg::job_t job_q, job_d;
  scms_pkg::vec_t h_q, h_d, a_q, a_d;
  logic signed [35:0]  facc_q, facc_d;
  logic signed [51:0]  d_q, d_d;
  logic                neg_q, neg_d;
  logic [50:0]         dabs_q, dabs_d;
  logic [114:0]        acc_q, acc_d;
  logic [2:0][51:0]    k_q, k_d;
  logic signed [65:0]  p_q;

  logic                ovld_q, ovld_d, oend_q, oend_d;
  scms_pkg::vec_t      onew_q, onew_d;

  logic signed [32:0]  ma, mb;
  logic signed [65:0]  prod, t30, t14;
  logic signed [35:0]  r30, fsum;
  logic signed [51:0]  r14;
  logic [31:0]         src, extra;
  logic                load;

  assign prod = ma * mb;
  assign t30  = p_q + 66'sh2000_0000;
  assign t14  = p_q + 66'sh2000;
  assign r30  = t30[65:30];
  assign r14  = t14[65:14];
  assign load = (state_q == scms_pkg::ST_RES) && (!ovld_q || result_o.ready);

  assign result_o.valid     = ovld_q;
  assign result_o.new_x     = onew_q[0];
  assign result_o.new_y     = onew_q[1];
  assign result_o.new_z     = onew_q[2];
  assign result_o.chain_end = oend_q;

  always_comb begin
    q_pop_o = (state_q == scms_pkg::ST_IDLE) && q_i.vld;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scms_pkg::ST_IDLE: if (q_i.vld) state_d = scms_pkg::ST_FLD;
      scms_pkg::ST_FLD:  if (ph_q && fld_q == 3'd5) state_d = scms_pkg::ST_CRS;
      scms_pkg::ST_CRS: begin
        if (sub_q == scms_pkg::SUB_K && axis_q == 2'd2) begin
          state_d = stage_q ? scms_pkg::ST_RES : scms_pkg::ST_MID;
        end
      end
      scms_pkg::ST_MID:  state_d = scms_pkg::ST_CRS;
      scms_pkg::ST_RES:  if (load) state_d = scms_pkg::ST_IDLE;
      default:           state_d = scms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    src = fld_q[0] ? job_q.r[fld_q[2:1]] : job_q.l[fld_q[2:1]];
    ma = '0;
    mb = '0;
    case (state_q)
      scms_pkg::ST_FLD: begin
        ma = {exch_q[31], exch_q};
        mb = {src[31], src};
      end
      scms_pkg::ST_CRS: begin
        case (sub_q)
          scms_pkg::SUB_CRS0: begin
            ma = {a_q[scms_pkg::nxt3(scms_pkg::nxt3(axis_q))][31],
                  a_q[scms_pkg::nxt3(scms_pkg::nxt3(axis_q))]};
            mb = {h_q[scms_pkg::nxt3(axis_q)][31], h_q[scms_pkg::nxt3(axis_q)]};
          end
          scms_pkg::SUB_CRS1: begin
            ma = {a_q[scms_pkg::nxt3(axis_q)][31], a_q[scms_pkg::nxt3(axis_q)]};
            mb = {h_q[scms_pkg::nxt3(scms_pkg::nxt3(axis_q))][31],
                  h_q[scms_pkg::nxt3(scms_pkg::nxt3(axis_q))]};
          end
          scms_pkg::SUB_PP0: begin
            ma = {1'b0, dabs_q[31:0]};
            mb = {1'b0, gamma_q[31:0]};
          end
          scms_pkg::SUB_PP1: begin
            ma = {14'b0, dabs_q[50:32]};
            mb = {1'b0, gamma_q[31:0]};
          end
          scms_pkg::SUB_PP2: begin
            ma = {1'b0, dabs_q[31:0]};
            mb = {2'b0, gamma_q[62:32]};
          end
          scms_pkg::SUB_PP3: begin
            ma = {14'b0, dabs_q[50:32]};
            mb = {2'b0, gamma_q[62:32]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [58:0] s;
    logic signed [51:0] tk;
    logic signed [42:0] rs;
    fld_d   = fld_q;
    axis_d  = axis_q;
    sub_d   = sub_q;
    stage_d = stage_q;
    ph_d    = ph_q;
    job_d   = job_q;
    h_d     = h_q;
    a_d     = a_q;
    facc_d  = facc_q;
    d_d     = d_q;
    neg_d   = neg_q;
    dabs_d  = dabs_q;
    acc_d   = acc_q;
    k_d     = k_q;
    onew_d  = onew_q;
    oend_d  = oend_q;
    ovld_d  = ovld_q && !result_o.ready;
    s       = '0;
    tk      = '0;
    rs      = '0;
    fsum    = facc_q + r30;
    case (fld_q[2:1])
      2'd0:    extra = pumpx_q;
      2'd2:    extra = biasz_q;
      default: extra = '0;
    endcase
    case (state_q)
      scms_pkg::ST_IDLE: begin
        if (q_i.vld) begin
          job_d   = q_i.job;
          a_d     = q_i.job.m;
          facc_d  = '0;
          fld_d   = '0;
          ph_d    = 1'b0;
          stage_d = 1'b0;
        end
      end
      scms_pkg::ST_FLD: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (!fld_q[0]) begin
            facc_d = fsum;
          end else begin
            h_d[fld_q[2:1]] = scms_pkg::sat32({{28{fsum[35]}}, fsum} +
                                              {{32{extra[31]}}, extra});
            facc_d = '0;
          end
          if (fld_q == 3'd5) begin
            axis_d = '0;
            sub_d  = scms_pkg::SUB_CRS0;
          end else begin
            fld_d = fld_q + 3'd1;
          end
        end
      end
      scms_pkg::ST_CRS: begin
        if (sub_q == scms_pkg::SUB_ABS) begin
          neg_d  = d_q[51];
          dabs_d = d_q[51] ? 51'(-d_q) : d_q[50:0];
          acc_d  = 115'd1 << 63;
          sub_d  = scms_pkg::SUB_PP0;
        end else if (sub_q == scms_pkg::SUB_K) begin
          k_d[axis_q] = neg_q ? -{1'b0, acc_q[114:64]} : {1'b0, acc_q[114:64]};
          sub_d  = scms_pkg::SUB_CRS0;
          axis_d = scms_pkg::nxt3(axis_q);
        end else begin
          ph_d = !ph_q;
          if (ph_q) begin
            sub_d = sub_q + 3'd1;
            case (sub_q)
              scms_pkg::SUB_CRS0: d_d = r14;
              scms_pkg::SUB_CRS1: d_d = d_q - r14;
              scms_pkg::SUB_PP0:  acc_d = acc_q + {51'b0, p_q[63:0]};
              scms_pkg::SUB_PP1,
              scms_pkg::SUB_PP2:  acc_d = acc_q + {19'b0, p_q[63:0], 32'b0};
              scms_pkg::SUB_PP3:  acc_d = acc_q + {p_q[50:0], 64'b0};
              default: ;
            endcase
          end
        end
      end
      scms_pkg::ST_MID: begin
        for (int i = 0; i < 3; i++) begin
          s = {{10{job_q.m[i][31]}}, job_q.m[i], 17'b0} +
              {k_q[i][51], k_q[i], 6'b0} + 59'sh10000;
          a_d[i] = scms_pkg::sat32({{22{s[58]}}, s[58:17]});
        end
        stage_d = 1'b1;
        axis_d  = '0;
        sub_d   = scms_pkg::SUB_CRS0;
        ph_d    = 1'b0;
      end
      scms_pkg::ST_RES: begin
        if (load) begin
          for (int i = 0; i < 3; i++) begin
            tk = k_q[i] + 52'sh200;
            rs = {tk[51], tk[51:10]} + {{11{job_q.m[i][31]}}, job_q.m[i]};
            onew_d[i] = scms_pkg::sat32({{21{rs[42]}}, rs});
          end
          oend_d = job_q.chain_end;
          ovld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scms_pkg::ST_IDLE;
      gamma_q <= scms_pkg::RST_STEP_GAMMA;
      exch_q  <= scms_pkg::RST_EXCHANGE;
      biasz_q <= scms_pkg::RST_BIAS_Z;
      pumpx_q <= scms_pkg::RST_PUMP_X;
      fld_q   <= '0;
      axis_q  <= '0;
      sub_q   <= scms_pkg::SUB_CRS0;
      stage_q <= 1'b0;
      ph_q    <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fld_q   <= fld_d;
      axis_q  <= axis_d;
      sub_q   <= sub_d;
      stage_q <= stage_d;
      ph_q    <= ph_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          scms_pkg::CFG_STEP_GAMMA: gamma_q <= cfg_data_i;
          scms_pkg::CFG_EXCHANGE:   exch_q  <= cfg_data_i[31:0];
          scms_pkg::CFG_BIAS_Z:     biasz_q <= cfg_data_i[31:0];
          scms_pkg::CFG_PUMP_X:     pumpx_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    h_q    <= h_d;
    a_q    <= a_d;
    facc_q <= facc_d;
    d_q    <= d_d;
    neg_q  <= neg_d;
    dabs_q <= dabs_d;
    acc_q  <= acc_d;
    k_q    <= k_d;
    p_q    <= prod;
    onew_q <= onew_d;
    oend_q <= oend_d;
  end

endmodule

// File: sv/spin_chain_midpoint_step_unit.sv
// The back end takes a new job only after registering the result of the last one,
// as every step of a job runs on the single shared 33x33 multiplier; a spin yields
// no, one or two results (two on a chain end after a held spin).
// The front end takes a spin when its two job slots are empty.
// Reset (async, active low) empties the window and queue and loads register defaults.
module spin_chain_midpoint_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [62:0]  cfg_data_i,
  scms_in_if.sink      spin_i,
  scms_out_if.source   result_o
);

  scms_pkg::q_item_t push_item, head_item;
  logic              q_full, q_pop;

  scms_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .spin_i   (spin_i),
    .q_full_i (q_full),
    .q_o      (push_item)
  );

  scms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_item),
    .full_o (q_full),
    .head_o (head_item),
    .pop_i  (q_pop)
  );

  scms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_i        (head_item),
    .q_pop_o    (q_pop),
    .result_o   (result_o)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for spin_chain_midpoint_step_unit: streams spin chains and
// predicts every updated spin in fixed point. Depends on scms_pkg and the two channel interfaces.
`timescale 1ns / 100ps

module tb_top;
  import scms_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        chain_end;
  } spin_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [62:0] cfg_data_i;

  scms_in_if  spin_if();
  scms_out_if res_if();

  spin_chain_midpoint_step_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .spin_i    (spin_if),
    .result_o  (res_if)
  );

  spin_res_t   spin_result_q[$];
  int          err_cnt = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  logic [62:0] step_gam;
  longint      exch_fld, bias_z, pump_x;
  vec3_t       left_spin, held_spin;
  bit          held_vld;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("spin_chain_midpoint_step_unit test failed");
    $finish;
  end

  function automatic longint rnd_shift(longint x, int n);
    logic signed [127:0] t;
    t = x;
    t = t + (128'sd1 <<< (n - 1));
    return longint'(t >>> n);
  endfunction

  function automatic longint sat_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint gamma_scale(longint d);
    logic [127:0] p;
    logic [63:0]  a;
    logic [63:0]  hi;
    a = (d < 0) ? -d : d;
    p = {64'd0, a} * {65'd0, step_gam};
    hi = p[127:64] + p[63];
    return (d < 0) ? -longint'(hi) : longint'(hi);
  endfunction

  function automatic longint prod40(longint a, longint h);
    return rnd_shift(a * h, 14);
  endfunction

  function automatic void precess(input vec3_t a, input vec3_t h, output vec3_t k);
    k[0] = gamma_scale(prod40(a[2], h[1]) - prod40(a[1], h[2]));
    k[1] = gamma_scale(prod40(a[0], h[2]) - prod40(a[2], h[0]));
    k[2] = gamma_scale(prod40(a[1], h[0]) - prod40(a[0], h[1]));
  endfunction

  function automatic longint field_of(longint a, longint b, longint extra);
    return sat_q(rnd_shift(exch_fld * a, 30) + rnd_shift(exch_fld * b, 30) + extra);
  endfunction

  function automatic void push_update(input vec3_t m, input vec3_t l, input vec3_t r,
                                      input bit last);
    vec3_t     h, a, k1, k2;
    spin_res_t res;
    h[0] = field_of(l[0], r[0], pump_x);
    h[1] = field_of(l[1], r[1], 0);
    h[2] = field_of(l[2], r[2], bias_z);
    precess(m, h, k1);
    for (int i = 0; i < 3; i++) a[i] = sat_q(rnd_shift(m[i] * 131072 + k1[i] * 64, 17));
    precess(a, h, k2);
    res.x = 32'(sat_q(m[0] + rnd_shift(k2[0], 10)));
    res.y = 32'(sat_q(m[1] + rnd_shift(k2[1], 10)));
    res.z = 32'(sat_q(m[2] + rnd_shift(k2[2], 10)));
    res.chain_end = last;
    spin_result_q.push_back(res);
  endfunction

  function automatic void predict_spin(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic last);
    vec3_t cur, zero;
    cur[0] = longint'(signed'(x));
    cur[1] = longint'(signed'(y));
    cur[2] = longint'(signed'(z));
    zero = '{0, 0, 0};
    if (held_vld) push_update(held_spin, left_spin, cur, 1'b0);
    if (last) begin
      push_update(cur, held_spin, zero, 1'b1);
      left_spin = zero;
      held_spin = zero;
      held_vld = 1'b0;
    end else begin
      left_spin = held_spin;
      held_spin = cur;
      held_vld = 1'b1;
    end
  endfunction

  // caller sits just after a rising edge
  task automatic send_spin(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    while (idle_on && $urandom_range(99) < 20) begin
      spin_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    spin_if.valid     <= 1'b1;
    spin_if.mag_x     <= x;
    spin_if.mag_y     <= y;
    spin_if.mag_z     <= z;
    spin_if.last_spin <= last;
    forever begin
      @(negedge clk_i);
      if (spin_if.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    predict_spin(x, y, z, last);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [62:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_GAMMA: step_gam = data;
      CFG_EXCHANGE:   exch_fld = longint'(signed'(data[31:0]));
      CFG_BIAS_Z:     bias_z   = longint'(signed'(data[31:0]));
      default:        pump_x   = longint'(signed'(data[31:0]));
    endcase
  endtask

  task automatic drain();
    spin_if.valid <= 1'b0;
    @(posedge clk_i);
    while (spin_result_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [62:0] g, logic [31:0] e, logic [31:0] b, logic [31:0] p);
    drain();
    write_reg(CFG_STEP_GAMMA, g);
    write_reg(CFG_EXCHANGE, {31'd0, e});
    write_reg(CFG_BIAS_Z, {31'd0, b});
    write_reg(CFG_PUMP_X, {31'd0, p});
  endtask

  function automatic logic [31:0] rand_comp();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 32'($urandom_range(32'h7fff_ffff) - 32'h4000_0000);
    if (sel < 8) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h4000_0000;
      3: return 32'hc000_0000;
      default: return 32'h0;
    endcase
  endfunction

  task automatic send_chains(int n_items);
    int left_in_chain;
    left_in_chain = $urandom_range(12, 1);
    for (int i = 0; i < n_items; i++) begin
      left_in_chain--;
      send_spin(rand_comp(), rand_comp(), rand_comp(), left_in_chain == 0);
      if (left_in_chain == 0) left_in_chain = $urandom_range(12, 1);
    end
  endtask

  task automatic test_directed();
    send_spin(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1);
    send_spin(32'h4000_0000, 32'h0, 32'h0, 1'b0);
    send_spin(32'h0, 32'h4000_0000, 32'h0, 1'b1);
    send_spin(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_spin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_spin(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_spin(32'h0, 32'h0, 32'h4000_0000, 1'b1);
    send_spin(32'hffff_ffff, 32'h0000_0001, 32'h8000_0001, 1'b0);
    send_spin(32'h0, 32'h0, 32'h0, 1'b1);
  endtask

  task automatic test_reg_extremes();
    set_regs(63'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    test_directed();
    set_regs(63'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    test_directed();
    set_regs(63'h0000_ffff_ffff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_chains(40);
  endtask

  task automatic test_random_regs();
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(63'({$urandom, $urandom} >> $urandom_range(40, 1)), $urandom, $urandom,
               $urandom);
      send_chains(150);
    end
  endtask

  task automatic test_no_idle();
    set_regs(RST_STEP_GAMMA * 1000, RST_EXCHANGE, RST_BIAS_Z, RST_PUMP_X);
    idle_on = 1'b0;
    send_chains(300);
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    hold_req = 1'b1;
    send_chains(60);
  endtask

  always begin
    @(posedge clk_i);
    if (hold_req) begin
      res_if.ready <= 1'b0;
      repeat (800) @(posedge clk_i);
      hold_req = 1'b0;
    end
    res_if.ready <= !(idle_on && $urandom_range(99) < 20);
    @(negedge clk_i);
    if (res_if.valid && res_if.ready) begin
      if (spin_result_q.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        spin_res_t e;
        e = spin_result_q.pop_front();
        if (res_if.new_x !== e.x) begin
          $error("new_x: expected %h, got %h", e.x, res_if.new_x); err_cnt++;
        end
        if (res_if.new_y !== e.y) begin
          $error("new_y: expected %h, got %h", e.y, res_if.new_y); err_cnt++;
        end
        if (res_if.new_z !== e.z) begin
          $error("new_z: expected %h, got %h", e.z, res_if.new_z); err_cnt++;
        end
        if (res_if.chain_end !== e.chain_end) begin
          $error("chain_end: expected %b, got %b", e.chain_end, res_if.chain_end); err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_STEP_GAMMA;
    cfg_data_i        = '0;
    spin_if.valid     = 1'b0;
    spin_if.mag_x     = '0;
    spin_if.mag_y     = '0;
    spin_if.mag_z     = '0;
    spin_if.last_spin = 1'b0;
    res_if.ready      = 1'b0;
    step_gam = RST_STEP_GAMMA;
    exch_fld = longint'(signed'(RST_EXCHANGE));
    bias_z   = longint'(signed'(RST_BIAS_Z));
    pump_x   = longint'(signed'(RST_PUMP_X));
    left_spin = '{0, 0, 0};
    held_spin = '{0, 0, 0};
    held_vld  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_directed();
    send_chains(60);
    test_reg_extremes();
    test_random_regs();
    test_no_idle();
    test_back_pressure();
    send_chains(100);
    set_regs(RST_STEP_GAMMA, RST_EXCHANGE, RST_BIAS_Z, RST_PUMP_X);
    send_chains(100);
    drain();
    if (err_cnt == 0) begin
      $display("spin_chain_midpoint_step_unit test passed");
    end else begin
      $display("spin_chain_midpoint_step_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/scms_pkg.sv
sv/scms_in_if.sv
sv/scms_out_if.sv
sv/scms_front.sv
sv/scms_queue.sv
sv/scms_back.sv
sv/spin_chain_midpoint_step_unit.sv
test/tb_top.sv
